### rtl/core/rorbp_pkg.sv
// Shared types, constants and control-store codes for the object record bit packer.
package rorbp_pkg;

  // Input and result words
  typedef struct packed {
    logic [4:0]  item_code;
    logic [1:0]  addr_type;
    logic [15:0] field_value;
    logic [3:0]  sym_len;
    logic [63:0] sym_chars;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
  } result_t;

  localparam int MaxSymbolChars = 8;
  localparam logic [3:0] MAX_SYM = 4'(MaxSymbolChars);
  localparam logic [2:0] SYM_LEN_BITS_RESET = 3'd4;

  // Item codes
  localparam logic [4:0] CODE_ABS      = 5'd0;
  localparam logic [4:0] CODE_REL_LAST = 5'd3;
  localparam logic [4:0] CODE_LNK_BASE = 5'd4;
  localparam logic [4:0] CODE_LNK_LAST = 5'd19;

  // Link subcodes
  localparam logic [3:0] SUB_SYM_LAST  = 4'd4;
  localparam logic [3:0] SUB_VSYM_FRST = 4'd5;
  localparam logic [3:0] SUB_VSYM_LAST = 4'd7;
  localparam logic [3:0] SUB_END_PROG  = 4'd14;

  // Control-store addresses
  localparam int PcW = 4;
  localparam logic [PcW-1:0] A_ABS = 4'd0;
  localparam logic [PcW-1:0] A_REL = 4'd2;
  localparam logic [PcW-1:0] A_LNK = 4'd5;
  localparam logic [PcW-1:0] A_VAL = 4'd6;
  localparam logic [PcW-1:0] A_SYM = 4'd9;
  localparam logic [PcW-1:0] A_CHR = 4'd10;
  localparam logic [PcW-1:0] A_PAD = 4'd11;

  // Data sources
  localparam logic [3:0] S_NONE    = 4'd0;
  localparam logic [3:0] S_ABS_HDR = 4'd1;
  localparam logic [3:0] S_REL_HDR = 4'd2;
  localparam logic [3:0] S_LNK_HDR = 4'd3;
  localparam logic [3:0] S_LOW     = 4'd4;
  localparam logic [3:0] S_HIGH    = 4'd5;
  localparam logic [3:0] S_TYPE    = 4'd6;
  localparam logic [3:0] S_LEN     = 4'd7;
  localparam logic [3:0] S_CHAR    = 4'd8;
  localparam logic [3:0] S_PAD     = 4'd9;

  // Sequencing conditions
  localparam logic [2:0] C_NEXT = 3'd0;
  localparam logic [2:0] C_END  = 3'd1;
  localparam logic [2:0] C_LNK  = 3'd2;
  localparam logic [2:0] C_VAL  = 3'd3;
  localparam logic [2:0] C_LEN  = 3'd4;
  localparam logic [2:0] C_CHAR = 3'd5;

  typedef struct packed {
    logic [3:0] src;
    logic [2:0] cond;
  } ctrl_t;

  // Bit push request and accumulator status
  typedef struct packed {
    logic       en;
    logic [7:0] data;
    logic [3:0] nbits;
  } push_t;

  typedef struct packed {
    logic       done;
    logic [7:0] byte_val;
    logic [3:0] free;
  } acc_stat_t;

endpackage

### rtl/core/rorbp_rom.sv
// Control store: one control word per sequencer step.
module rorbp_rom (
  input  logic [rorbp_pkg::PcW-1:0] pc,
  output rorbp_pkg::ctrl_t          ctrl
);
  import rorbp_pkg::*;

  // Record programs, entered at A_ABS, A_REL or A_LNK
  always_comb begin
    case (pc)
      4'd0:    ctrl = '{src: S_ABS_HDR, cond: C_NEXT};
      4'd1:    ctrl = '{src: S_LOW,     cond: C_END};
      4'd2:    ctrl = '{src: S_REL_HDR, cond: C_NEXT};
      4'd3:    ctrl = '{src: S_LOW,     cond: C_NEXT};
      4'd4:    ctrl = '{src: S_HIGH,    cond: C_END};
      4'd5:    ctrl = '{src: S_LNK_HDR, cond: C_LNK};
      4'd6:    ctrl = '{src: S_TYPE,    cond: C_NEXT};
      4'd7:    ctrl = '{src: S_LOW,     cond: C_NEXT};
      4'd8:    ctrl = '{src: S_HIGH,    cond: C_VAL};
      4'd9:    ctrl = '{src: S_LEN,     cond: C_LEN};
      4'd10:   ctrl = '{src: S_CHAR,    cond: C_CHAR};
      4'd11:   ctrl = '{src: S_PAD,     cond: C_END};
      default: ctrl = '{src: S_NONE,    cond: C_END};
    endcase
  end

endmodule

### rtl/core/rorbp_acc.sv
// Bit accumulator: appends up to eight bits MSB-first and reports a completed byte.
module rorbp_acc (
  input  logic                  clk,
  input  logic                  rst,
  input  rorbp_pkg::push_t      push,
  output rorbp_pkg::acc_stat_t  stat
);
  import rorbp_pkg::*;

  logic [7:0]  acc;
  logic [3:0]  free;
  logic [15:0] wide;
  logic [15:0] in_mask;
  logic [3:0]  rem;
  logic [15:0] rem_mask;

  // Pending bits followed by the new field; the byte is the top eight of them
  always_comb begin
    in_mask  = (16'd1 << push.nbits) - 16'd1;
    wide     = ({8'd0, acc} << push.nbits) | ({8'd0, push.data} & in_mask);
    rem      = push.nbits - free;
    rem_mask = (16'd1 << rem) - 16'd1;
    stat.done     = push.nbits >= free;
    stat.byte_val = 8'(wide >> rem);
    stat.free     = free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      free <= 4'd8;
    end else if (push.en) begin
      if (stat.done) begin
        acc  <= 8'(wide & rem_mask);
        free <= 4'd8 - rem;
      end else begin
        acc  <= wide[7:0];
        free <= free - push.nbits;
      end
    end
  end

endmodule

### rtl/core/rel_object_record_bit_packer.sv
// Top level of the object record bit packer: sequencer, operand select and output words.
// Each accepted item is one object record, run as a short program from a control store
// that appends one field (at most eight bits) to the bit accumulator per step, so at most
// one byte completes per step. A record is taken while idle, then runs its field steps
// and a flush step; a stalled output holds byte-completing steps and the flush.
// Input is taken only while the sequencer is idle. The newest byte of a record is held
// back until a newer byte displaces it or the flush, so that its last byte can be marked.
// The symbol length width is set through the configuration write port; write it only
// while no record is in flight.
module rel_object_record_bit_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  rorbp_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output rorbp_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);
  import rorbp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]     state;
  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;
  logic           seq_end;
  logic [2:0]     chr;
  item_t          cur;
  logic [2:0]     sym_len_bits;
  logic [7:0]     held;
  logic           held_valid;
  ctrl_t          ctrl;
  push_t          push;
  acc_stat_t      stat;
  logic [3:0]     sub;
  logic [3:0]     len_c;
  logic           out_free;
  logic           step_go;
  logic [PcW-1:0] entry;
  logic           emit_mid;
  logic           emit_last;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_len_bits <= SYM_LEN_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sym_len_bits <= cfg_data;
    end
  end

  rorbp_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  rorbp_acc u_acc (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .stat (stat)
  );

  assign sub   = 4'(cur.item_code - CODE_LNK_BASE);
  assign len_c = (cur.sym_len > MAX_SYM) ? MAX_SYM : cur.sym_len;

  // Program entry by record class
  always_comb begin
    if (item.item_code == CODE_ABS) begin
      entry = A_ABS;
    end else if (item.item_code <= CODE_REL_LAST) begin
      entry = A_REL;
    end else begin
      entry = A_LNK;
    end
  end

  // Hold the step while a new byte has nowhere to go
  assign step_go = (state == ST_RUN) && !(stat.done && held_valid && !out_free);

  // Operand select for the current step
  always_comb begin
    push.en    = step_go;
    push.data  = '0;
    push.nbits = '0;
    case (ctrl.src)
      S_ABS_HDR: begin
        push.data  = 8'd0;
        push.nbits = 4'd1;
      end
      S_REL_HDR: begin
        push.data  = {5'd0, 1'b1, cur.item_code[1:0]};
        push.nbits = 4'd3;
      end
      S_LNK_HDR: begin
        push.data  = {1'b0, 3'b100, sub};
        push.nbits = 4'd7;
      end
      S_LOW: begin
        push.data  = cur.field_value[7:0];
        push.nbits = 4'd8;
      end
      S_HIGH: begin
        push.data  = cur.field_value[15:8];
        push.nbits = 4'd8;
      end
      S_TYPE: begin
        push.data  = {6'd0, cur.addr_type};
        push.nbits = 4'd2;
      end
      S_LEN: begin
        push.data  = {4'd0, len_c};
        push.nbits = {1'b0, sym_len_bits};
      end
      S_CHAR: begin
        push.data  = cur.sym_chars[{chr, 3'b000} +: 8];
        push.nbits = 4'd8;
      end
      S_PAD: begin
        push.data  = 8'd0;
        push.nbits = (stat.free == 4'd8) ? 4'd0 : stat.free;
      end
      default: begin
        push.data  = '0;
        push.nbits = '0;
      end
    endcase
  end

  // Next step address
  always_comb begin
    pc_next = pc + 1'b1;
    seq_end = 1'b0;
    case (ctrl.cond)
      C_NEXT: pc_next = pc + 1'b1;
      C_END:  seq_end = 1'b1;
      C_LNK: begin
        if (cur.item_code > CODE_LNK_LAST) begin
          seq_end = 1'b1;
        end else begin
          case (sub) inside
            [4'd0:SUB_SYM_LAST]:          pc_next = A_SYM;
            [SUB_VSYM_FRST:SUB_END_PROG]: pc_next = A_VAL;
            default:                      pc_next = A_PAD;
          endcase
        end
      end
      C_VAL: begin
        if (sub >= SUB_VSYM_FRST && sub <= SUB_VSYM_LAST) begin
          pc_next = A_SYM;
        end else if (sub == SUB_END_PROG) begin
          pc_next = A_PAD;
        end else begin
          seq_end = 1'b1;
        end
      end
      C_LEN: begin
        if (len_c == 4'd0) begin
          seq_end = 1'b1;
        end else begin
          pc_next = A_CHR;
        end
      end
      C_CHAR: begin
        if (({1'b0, chr} + 4'd1) < len_c) begin
          pc_next = pc;
        end else begin
          seq_end = 1'b1;
        end
      end
      default: seq_end = 1'b1;
    endcase
  end

  // Held byte leaves when a newer one displaces it, or as the last one at flush
  assign emit_mid  = step_go && stat.done && held_valid;
  assign emit_last = (state == ST_FLUSH) && held_valid && out_free;

  // Sequencer, held byte and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pc           <= A_ABS;
      chr          <= '0;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit_mid || emit_last) begin
        result_valid        <= 1'b1;
        result.out_byte     <= held;
        result.last_of_item <= emit_last;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid && !item_stall) begin
            cur   <= item;
            pc    <= entry;
            chr   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_go) begin
            if (stat.done) begin
              held       <= stat.byte_val;
              held_valid <= 1'b1;
            end
            if (ctrl.cond == C_CHAR) begin
              chr <= chr + 1'b1;
            end
            if (seq_end) begin
              state <= ST_FLUSH;
            end else begin
              pc <= pc_next;
            end
          end
        end
        ST_FLUSH: begin
          if (!held_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            held_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### sim/rel_object_record_bit_packer_tb.sv
// Testbench for the object record bit packer: directed records, random records, bitstream scoreboard.
module rel_object_record_bit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rorbp_pkg::*;

  // Record codes not named in the package
  localparam logic [4:0] CODE_REL_PROG = 5'd1;
  localparam logic [4:0] CODE_REL_DATA = 5'd2;
  localparam logic [4:0] CODE_MAX      = 5'd31;
  localparam logic [3:0] SUB_END_FILE  = 4'd15;
  // Leading tag bits of each record format
  localparam logic [7:0] TAG_ABS  = 8'd0;
  localparam logic [7:0] TAG_REL  = 8'd1;
  localparam logic [7:0] TAG_LINK = 8'd4;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD    = 200;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 22;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item_word = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result_word;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [2:0] cfg_data = '0;

  rel_object_record_bit_packer DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Directed stimulus row: a record and, where obvious, its bytes typed in
  typedef struct packed {
    item_t           rec;
    logic [1:0]      n_typed;
    logic [1:0][7:0] typed;
  } row_t;

  row_t    directed_rows[$];
  result_t expected_bytes[$];
  result_t record_bytes[$];
  logic [7:0] pend_bits = 8'd0;
  logic [3:0] free_cnt  = 4'd8;
  logic [2:0] len_width = SYM_LEN_BITS_RESET;
  logic    no_idle = 1'b0;
  logic    long_hold_req = 1'b0;
  int      errors = 0;
  int      cycle_count = 0;
  result_t want;
  int      hold_left = 0;
  int      burst_left = 0;
  bit      long_hold_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rel_object_record_bit_packer_tb NOT OK");
      $finish;
    end
  end

  // Bitstream predictor: append bits MSB first, collect each completed byte
  function automatic void shift_in_bits(input logic [7:0] val, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) begin
      pend_bits = {pend_bits[6:0], (i < 8) ? val[i] : 1'b0};
      free_cnt--;
      if (free_cnt == 4'd0) begin
        record_bytes.push_back('{out_byte: pend_bits, last_of_item: 1'b0});
        pend_bits = 8'd0;
        free_cnt  = 4'd8;
      end
    end
  endfunction

  function automatic void shift_in_value(input logic [15:0] v);
    shift_in_bits(v[7:0], 8);
    shift_in_bits(v[15:8], 8);
  endfunction

  // Length clamps to the maximum; only the low len_width bits are written
  function automatic void shift_in_symbol(input logic [3:0] slen, input logic [63:0] chars);
    logic [3:0] n;
    n = (slen > MAX_SYM) ? MAX_SYM : slen;
    shift_in_bits(8'(n), int'(len_width));
    for (int k = 0; k < int'(n); k++)
      shift_in_bits(chars[8*k +: 8], 8);
  endfunction

  function automatic void pack_record(input item_t it);
    logic [3:0] sub;
    record_bytes.delete();
    sub = 4'(it.item_code - CODE_LNK_BASE);
    if (it.item_code == CODE_ABS) begin
      shift_in_bits(TAG_ABS, 1);
      shift_in_bits(it.field_value[7:0], 8);
    end else if (it.item_code <= CODE_REL_LAST) begin
      shift_in_bits(TAG_REL, 1);
      shift_in_bits(8'(it.item_code), 2);
      shift_in_value(it.field_value);
    end else begin
      shift_in_bits(TAG_LINK, 3);
      shift_in_bits(8'(sub), 4);
      // unknown codes stop after the subcode
      if (it.item_code <= CODE_LNK_LAST) begin
        if (sub >= SUB_VSYM_FRST && sub <= SUB_VSYM_LAST) begin
          shift_in_bits(8'(it.addr_type), 2);
          shift_in_value(it.field_value);
          shift_in_symbol(it.sym_len, it.sym_chars);
        end else if (sub <= SUB_SYM_LAST) begin
          shift_in_symbol(it.sym_len, it.sym_chars);
        end else if (sub <= SUB_END_PROG) begin
          shift_in_bits(8'(it.addr_type), 2);
          shift_in_value(it.field_value);
        end
        if (sub >= SUB_END_PROG && free_cnt < 4'd8)
          shift_in_bits(8'd0, int'(free_cnt));
      end
    end
    if (record_bytes.size() > 0)
      record_bytes[record_bytes.size() - 1].last_of_item = 1'b1;
  endfunction

  // Offer one record; on acceptance queue its bytes
  task automatic send_record(input item_t it, input logic [1:0] n_typed,
                             input logic [1:0][7:0] typed);
    @(negedge clk);
    item_valid <= 1'b1;
    item_word  <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pack_record(it);
    if (n_typed != 2'd0) begin
      record_bytes.delete();
      for (int k = 0; k < int'(n_typed); k++)
        record_bytes.push_back('{out_byte: typed[k], last_of_item: (k == int'(n_typed) - 1)});
    end
    foreach (record_bytes[k]) expected_bytes.push_back(record_bytes[k]);
    // sender gap
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
  endtask

  // Wait until every queued byte has come out and the sequencer has settled
  task automatic drain_all();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_len_width(input logic [2:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    len_width = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t rand_record();
    item_t r;
    if ($urandom_range(0, 9) == 0)
      r.item_code = 5'($urandom_range(int'(CODE_LNK_LAST) + 1, int'(CODE_MAX)));
    else
      r.item_code = 5'($urandom_range(int'(CODE_ABS), int'(CODE_LNK_LAST)));
    r.addr_type   = 2'($urandom);
    r.field_value = 16'($urandom);
    if ($urandom_range(0, 4) == 0)
      r.sym_len = 4'($urandom_range(MaxSymbolChars + 1, 15));
    else
      r.sym_len = 4'($urandom_range(0, MaxSymbolChars));
    r.sym_chars = {$urandom, $urandom};
    return r;
  endfunction

  function automatic void add_row(input logic [4:0] code, input logic [1:0] atype,
                                  input logic [15:0] val, input logic [3:0] slen,
                                  input logic [63:0] chars, input logic [1:0] n,
                                  input logic [7:0] b0, input logic [7:0] b1);
    row_t r;
    r.rec = '{item_code: code, addr_type: atype, field_value: val,
              sym_len: slen, sym_chars: chars};
    r.n_typed  = n;
    r.typed[0] = b0;
    r.typed[1] = b1;
    directed_rows.push_back(r);
  endfunction

  // Receiver stall: one long hold on request, none while no_idle is set, else random bursts
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      hold_left = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (no_idle) begin
      result_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(1, 9) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Scoreboard: each accepted byte against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: byte with none expected: expected none, actual %h last %b",
                 $time, result_word.out_byte, result_word.last_of_item);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (result_word.out_byte !== want.out_byte ||
            result_word.last_of_item !== want.last_of_item) begin
          $display("%0t: mismatch: expected %h last %b, actual %h last %b", $time,
                   want.out_byte, want.last_of_item,
                   result_word.out_byte, result_word.last_of_item);
          errors++;
        end
      end
    end
  end

  logic [2:0] phase_widths [PHASES] = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd3,
                                        3'd5, 3'd1, 3'd2, 3'd6, 3'd4};

  initial begin
    logic [1:0][7:0] no_bytes;
    no_bytes = '0;

    // Directed table; the first rows start from the reset state
    add_row(CODE_ABS, 2'd0, 16'h00FF, 4'd0, '0, 2'd1, 8'h7F, 8'h00);
    add_row(CODE_LNK_BASE + 5'(SUB_END_FILE), 2'd0, 16'h0000, 4'd0, '0, 2'd1, 8'hCF, 8'h00);
    add_row(CODE_REL_LAST, 2'd0, 16'hFFFF, 4'd0, '0, 2'd2, 8'hFF, 8'hFF);
    add_row(CODE_LNK_BASE + 5'(SUB_END_FILE), 2'd0, 16'h0000, 4'd0, '0, 2'd2, 8'hF3, 8'hC0);
    add_row(CODE_ABS, 2'd3, 16'hFF00, 4'd15, '1, 2'd0, 8'h00, 8'h00);
    add_row(CODE_REL_PROG, 2'd1, 16'h1234, 4'd0, '0, 2'd0, 8'h00, 8'h00);
    add_row(CODE_REL_DATA, 2'd2, 16'h0000, 4'd8, '1, 2'd0, 8'h00, 8'h00);
    // every link subcode, symbol lengths spread over 0..15
    for (int s = 0; s < 16; s++)
      add_row(CODE_LNK_BASE + 5'(s), 2'(s),
              (s % 3 == 0) ? 16'hFFFF : (s % 3 == 1) ? 16'h0000 : 16'hA55A,
              4'(s * 7), (s % 2 == 1) ? '1 : 64'h0123_4567_89AB_CDEF,
              2'd0, 8'h00, 8'h00);
    // value plus a full symbol: the longest record
    add_row(CODE_LNK_BASE + 5'(SUB_VSYM_LAST), 2'd3, 16'hFFFF, MAX_SYM, '1,
            2'd0, 8'h00, 8'h00);
    add_row(CODE_LNK_LAST + 5'd1, 2'd3, 16'hFFFF, 4'd8, '1, 2'd0, 8'h00, 8'h00);
    add_row(CODE_MAX, 2'd0, 16'h0000, 4'd0, '0, 2'd0, 8'h00, 8'h00);
    add_row(CODE_LNK_BASE + 5'(SUB_END_FILE), 2'd0, 16'h0000, 4'd0, '0, 2'd0, 8'h00, 8'h00);

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_record(directed_rows[i].rec, directed_rows[i].n_typed, directed_rows[i].typed);
    drain_all();

    // Random phases, one length width each
    for (int p = 0; p < PHASES; p++) begin
      write_len_width(phase_widths[p]);
      if (p == 2) long_hold_req = 1'b1;
      if (p == PHASES - 1) no_idle = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_record(rand_record(), 2'd0, no_bytes);
      drain_all();
    end

    if (errors == 0) begin
      $display("rel_object_record_bit_packer_tb OK");
    end else begin
      $display("rel_object_record_bit_packer_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rorbp_pkg.sv
rtl/core/rorbp_rom.sv
rtl/core/rorbp_acc.sv
rtl/core/rel_object_record_bit_packer.sv
sim/rel_object_record_bit_packer_tb.sv
